// ===== src/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check that a condition implies a consequence on the same edge
`define ASSERT_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// check that a condition implies a consequence on the next edge
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// ===== src/nnwp_pkg.sv =====
// shared types and constants of the nearest neighbour weighted predictor
package nnwp_pkg;
  localparam int MaxKept = 16;
  localparam int KeptW = $clog2(MaxKept + 1);
  localparam int IdxW = $clog2(MaxKept);
  localparam logic [4:0] NeighbourReset = 5'd4;
  localparam logic [32:0] Log2eQ32 = 33'd6196328019;
  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusShort = 2'd1;
  localparam logic [1:0] StatusTie = 2'd2;

  typedef enum logic [3:0] {
    S_COLLECT, S_SETUP, S_RDIV, S_EXPT, S_MANT, S_WSHIFT, S_MUL, S_ACC,
    S_MLOAD, S_MDIV, S_DONE
  } state_t;

  typedef struct packed {
    logic insert;
    logic clear;
    logic setup;
    logic rdiv_start;
    logic rdiv_step;
    logic expt;
    logic mant_start;
    logic mant_step;
    logic wshift;
    logic mul;
    logic acc;
    logic next_entry;
    logic mdiv_start;
    logic mdiv_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic short_list;
    logic exact;
    logic entry_done;
    logic count_done;
  } sts_t;

  // 2^-(2^-(j+1)) in q0.32, j = 0..15
  function automatic logic [31:0] halving_root(input logic [3:0] j);
    logic [31:0] r;
    unique case (j)
      4'd0: r = 32'd3037000500;
      4'd1: r = 32'd3611622603;
      4'd2: r = 32'd3938502376;
      4'd3: r = 32'd4112874773;
      4'd4: r = 32'd4202935003;
      4'd5: r = 32'd4248701965;
      4'd6: r = 32'd4271771996;
      4'd7: r = 32'd4283353945;
      4'd8: r = 32'd4289156690;
      4'd9: r = 32'd4292061010;
      4'd10: r = 32'd4293513907;
      4'd11: r = 32'd4294240540;
      4'd12: r = 32'd4294603903;
      4'd13: r = 32'd4294785595;
      4'd14: r = 32'd4294876445;
      default: r = 32'd4294921870;
    endcase
    return r;
  endfunction
endpackage

// ===== src/nnwp_ctrl.sv =====
// controller state machine of the predictor
module nnwp_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic in_last,
  output logic out_valid,
  input  logic out_stall,
  input  nnwp_pkg::sts_t sts,
  output nnwp_pkg::cmd_t cmd
);
  import nnwp_pkg::*;
  `include "assert_macros.svh"

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_COLLECT: if (in_valid && in_last) state_next = S_SETUP;
      S_SETUP: begin
        if (sts.short_list) state_next = S_DONE;
        else if (sts.exact) state_next = S_ACC;
        else state_next = S_RDIV;
      end
      S_RDIV: if (sts.count_done) state_next = S_EXPT;
      S_EXPT: state_next = S_MANT;
      S_MANT: if (sts.count_done) state_next = S_WSHIFT;
      S_WSHIFT: state_next = S_MUL;
      S_MUL: state_next = S_ACC;
      S_ACC: begin
        if (sts.entry_done) state_next = S_MLOAD;
        else if (sts.exact) state_next = S_ACC;
        else state_next = S_RDIV;
      end
      S_MLOAD: state_next = S_MDIV;
      S_MDIV: if (sts.count_done) state_next = S_DONE;
      S_DONE: if (!out_stall) state_next = S_COLLECT;
      default: state_next = S_COLLECT;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = (state != S_COLLECT);
    out_valid = (state == S_DONE);
    unique case (state)
      S_COLLECT: begin
        cmd.insert = in_valid;
        cmd.setup = in_valid && in_last;
      end
      S_SETUP: cmd.rdiv_start = !sts.short_list && !sts.exact;
      S_RDIV: cmd.rdiv_step = 1'b1;
      S_EXPT: begin
        cmd.expt = 1'b1;
        cmd.mant_start = 1'b1;
      end
      S_MANT: cmd.mant_step = 1'b1;
      S_WSHIFT: cmd.wshift = 1'b1;
      S_MUL: cmd.mul = 1'b1;
      S_ACC: begin
        cmd.acc = 1'b1;
        cmd.next_entry = 1'b1;
        cmd.rdiv_start = !sts.entry_done && !sts.exact;
      end
      // sums are complete here, so the mean divider loads them
      S_MLOAD: cmd.mdiv_start = 1'b1;
      S_MDIV: cmd.mdiv_step = 1'b1;
      S_DONE: begin
        cmd.finish = !out_stall;
        cmd.clear = !out_stall;
      end
      default: ;
    endcase
  end

  `ASSERT_IMPL(a_ready_only_collect, clk, rst, !in_stall, state == S_COLLECT)
  `ASSERT_NEXT(a_last_leaves, clk, rst, in_valid && !in_stall && in_last, state == S_SETUP)
  `ASSERT_NEXT(a_done_holds, clk, rst, out_valid && out_stall, out_valid)
endmodule

// ===== src/nnwp_datapath.sv =====
// sorted cell list, weight unit, accumulators and dividers
module nnwp_datapath (
  input  logic clk,
  input  logic rst,
  input  logic [4:0] neighbour_count,
  input  logic [31:0] distance,
  input  logic signed [31:0] value,
  input  logic is_self,
  input  nnwp_pkg::cmd_t cmd,
  output nnwp_pkg::sts_t sts,
  output logic signed [31:0] prediction,
  output logic [4:0] neighbours_used,
  output logic exact_match,
  output logic [1:0] status
);
  import nnwp_pkg::*;
  `include "assert_macros.svh"

  logic [31:0] kd [MaxKept];
  logic signed [31:0] kv [MaxKept];
  logic [KeptW-1:0] kept_count;
  logic overflow_seen;

  // insertion position: entries with distance <= d stay in front
  logic [MaxKept-1:0] le;
  logic [KeptW-1:0] pos;
  always_comb begin
    pos = '0;
    for (int i = 0; i < MaxKept; i++) begin
      le[i] = (KeptW'(i) < kept_count) && (kd[i] <= distance);
      if (le[i]) pos = KeptW'(i + 1);
    end
  end

  wire full = (kept_count == KeptW'(MaxKept));

  always_ff @(posedge clk) begin
    if (cmd.insert && !is_self && !(full && pos == KeptW'(MaxKept))) begin
      for (int i = MaxKept - 1; i > 0; i--) begin
        if (KeptW'(i) > pos) begin
          kd[i] <= kd[i-1];
          kv[i] <= kv[i-1];
        end
      end
      for (int i = 0; i < MaxKept; i++) begin
        if (KeptW'(i) == pos) begin
          kd[i] <= distance;
          kv[i] <= value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      kept_count <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.insert && !is_self) begin
      if (!full) begin
        kept_count <= kept_count + 1'b1;
      end else if (pos == KeptW'(MaxKept)) begin
        if (distance == kd[MaxKept-1]) overflow_seen <= 1'b1;
      end else if (pos == KeptW'(MaxKept - 1)) begin
        overflow_seen <= (kd[MaxKept-1] == distance);
      end else begin
        overflow_seen <= (kd[MaxKept-1] == kd[MaxKept-2]);
      end
    end
  end

  // k clamped into 1..MaxKept
  logic [KeptW-1:0] k_eff;
  always_comb begin
    if (neighbour_count == 5'd0) k_eff = KeptW'(1);
    else if (6'(neighbour_count) > 6'(MaxKept)) k_eff = KeptW'(MaxKept);
    else k_eff = KeptW'(neighbour_count);
  end

  // setup: tie extension and zero-distance count, from the settled list
  logic [31:0] dk;
  logic [KeptW-1:0] n_ext, z_cnt;
  always_comb begin
    dk = kd[IdxW'(k_eff - 1'b1)];
    n_ext = k_eff;
    z_cnt = '0;
    for (int i = 0; i < MaxKept; i++) begin
      if (KeptW'(i) >= k_eff && KeptW'(i) < kept_count && kd[i] == dk)
        n_ext = KeptW'(i + 1);
      if (KeptW'(i) < kept_count && kd[i] == 32'd0) z_cnt = KeptW'(i + 1);
    end
  end

  logic short_q, exact_q;
  logic [1:0] status_r;
  logic [KeptW-1:0] n_r, idx;

  // latch setup results in the cycle after the last transfer
  logic setup_d;
  always_ff @(posedge clk) begin
    if (rst) setup_d <= 1'b0;
    else setup_d <= cmd.setup;
  end

  logic short_c, exact_c;
  assign short_c = (kept_count < k_eff);
  assign exact_c = !short_c && (kd[0] == 32'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      short_q <= 1'b0;
      exact_q <= 1'b0;
      status_r <= StatusOk;
      n_r <= '0;
      idx <= '0;
    end else begin
      if (setup_d) begin
        short_q <= short_c;
        exact_q <= exact_c;
        status_r <= (!short_c && overflow_seen && full && dk == kd[MaxKept-1])
                    ? StatusTie : (short_c ? StatusShort : StatusOk);
        n_r <= exact_c ? z_cnt : n_ext;
      end
      if (cmd.finish) idx <= '0;
      else if (cmd.next_entry) idx <= idx + 1'b1;
    end
  end

  // step counter shared by the serial dividers and the mantissa loop
  logic [6:0] cnt;

  always_comb begin
    sts.short_list = short_c;
    sts.exact = setup_d ? exact_c : exact_q;
    sts.entry_done = (idx + 1'b1 >= n_r);
    sts.count_done = (cnt == 7'd0);
  end

  // ratio divider: r = round(d*2^16/dmin), restoring, 49 quotient bits
  // dmin is the head of the list, which holds still while the query closes
  logic [48:0] rnum;
  logic [32:0] rrem;
  logic [48:0] rq;
  logic [IdxW-1:0] ridx;
  assign ridx = cmd.next_entry ? IdxW'(idx + 1'b1) : IdxW'(idx);
  wire [32:0] rtrial = {rrem[31:0], rnum[48]} - {1'b0, kd[0]};

  // exponent step
  logic [22:0] r_cap;
  logic [22:0] tval;
  logic [15:0] frac;
  logic [6:0] whole;
  logic [32:0] mant;
  logic [3:0] mj;
  logic [63:0] mprod;
  logic [31:0] w;
  logic signed [63:0] wv;
  logic signed [63:0] num;
  logic [47:0] wsum;

  always_comb begin
    r_cap = (rq > 49'(64 << 16)) ? 23'(64 << 16) : rq[22:0];
    tval = 23'((56'(r_cap) * 56'(Log2eQ32) + 56'h8000_0000) >> 32);
    // mantissa starts at exactly 1.0
    mprod = mant[32] ? {halving_root(mj), 32'd0} : mant[31:0] * halving_root(mj);
  end

  // mean divider, magnitude serial division
  logic [63:0] mag;
  logic [63:0] mq;
  logic [48:0] mrem;
  logic [47:0] den;
  wire [48:0] mtrial = {mrem[47:0], mag[63]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) cnt <= '0;
    else if (cmd.rdiv_start) cnt <= 7'd48;
    else if (cmd.mant_start) cnt <= 7'd15;
    else if (cmd.mdiv_start) cnt <= 7'd63;
    else if ((cmd.rdiv_step || cmd.mant_step || cmd.mdiv_step) && cnt != 7'd0)
      cnt <= cnt - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.rdiv_start) begin
      rnum <= {kd[ridx], 16'd0} + 49'(kd[0] >> 1);
      rrem <= '0;
    end else if (cmd.rdiv_step) begin
      if (!rtrial[32]) begin
        rrem <= rtrial;
        rq <= {rq[47:0], 1'b1};
      end else begin
        rrem <= {rrem[31:0], rnum[48]};
        rq <= {rq[47:0], 1'b0};
      end
      rnum <= {rnum[47:0], 1'b0};
    end
    if (cmd.expt) begin
      whole <= 7'(tval >> 16);
      frac <= tval[15:0];
    end else if (cmd.mant_step) begin
      frac <= {frac[14:0], 1'b0};
    end
    if (cmd.mant_start) begin
      mant <= 33'h1_0000_0000;
      mj <= '0;
    end else if (cmd.mant_step) begin
      if (frac[15]) mant <= 33'((mprod + 64'h8000_0000) >> 32);
      mj <= mj + 1'b1;
    end
    if (cmd.wshift) begin
      if (7'd16 + whole >= 7'd63) w <= '0;
      else w <= 32'((64'(mant) + (64'd1 << (7'd15 + whole))) >> (7'd16 + whole));
    end
    if (cmd.mul) wv <= $signed({1'b0, w}) * 64'(kv[IdxW'(idx)]);
    if (setup_d) begin
      num <= '0;
      wsum <= '0;
    end else if (cmd.acc) begin
      if (exact_q) begin
        num <= num + 64'(kv[IdxW'(idx)]);
        wsum <= wsum + 1'b1;
      end else begin
        num <= num + wv;
        wsum <= wsum + 48'(w);
      end
    end
    if (cmd.mdiv_start) begin
      mag <= (num[63] ? -num : num) + 64'(wsum >> 1);
      mrem <= '0;
      den <= wsum;
    end else if (cmd.mdiv_step) begin
      if (!mtrial[48]) begin
        mrem <= mtrial;
        mq <= {mq[62:0], 1'b1};
      end else begin
        mrem <= {mrem[47:0], mag[63]};
        mq <= {mq[62:0], 1'b0};
      end
      mag <= {mag[62:0], 1'b0};
    end
  end

  // result: the mean divider leaves its quotient in mq
  logic signed [31:0] pred_c;
  always_comb begin
    if (num[63]) pred_c = (mq > 64'd2147483648) ? 32'sh8000_0000 : -32'(mq);
    else pred_c = (mq > 64'd2147483647) ? 32'sh7fff_ffff : 32'(mq);
  end

  always_comb begin
    if (short_q) begin
      prediction = '0;
      neighbours_used = '0;
      exact_match = 1'b0;
    end else begin
      prediction = pred_c;
      neighbours_used = (n_r > KeptW'(31)) ? 5'd31 : 5'(n_r);
      exact_match = exact_q;
    end
    status = status_r;
  end

  `ASSERT_IMPL(a_count_cap, clk, rst, 1'b1, kept_count <= KeptW'(MaxKept))
  `ASSERT_NEXT(a_clear_empties, clk, rst, cmd.clear, kept_count == '0 && !overflow_seen)
endmodule

// ===== src/nearest_neighbour_weighted_predictor.sv =====
// top level of the nearest neighbour weighted predictor
// Usage:
//   input channel (in_valid/in_stall) carries one library point per transfer:
//   distance, value, is_self, last_point. While in_stall is low, points
//   stream at one per cycle into a sorted list of 16 cells; is_self points
//   are not kept. The transfer with last_point set closes the query.
//   in_stall then rises while the weights are computed: per neighbour a
//   49-step ratio division, the exponent, a 16-step mantissa loop, then
//   shift, multiply and accumulate; at the end a mean divider load and a
//   64-step mean division. Exact-distance queries skip the weight steps
//   and average the zero-distance entries; a query with too few points
//   goes straight to the result. One result transfer (out_valid/out_stall)
//   follows each closing point. out_valid holds with a steady payload while
//   out_stall is high; the list clears and the next query starts once the
//   result is taken. cfg_we writes neighbour_count (reset 4); the user
//   writes it only while the block is idle; the block has no check for it.
//   rst is synchronous, active high: list empty, controller idle.
module nearest_neighbour_weighted_predictor (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [4:0] cfg_wdata,
  input  logic in_valid,
  output logic in_stall,
  input  logic [31:0] distance,
  input  logic signed [31:0] value,
  input  logic is_self,
  input  logic last_point,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [31:0] prediction,
  output logic [4:0] neighbours_used,
  output logic exact_match,
  output logic [1:0] status
);
  import nnwp_pkg::*;

  logic [4:0] neighbour_count;
  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk) begin
    if (rst) neighbour_count <= NeighbourReset;
    else if (cfg_we) neighbour_count <= cfg_wdata;
  end

  nnwp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_last(last_point), .out_valid(out_valid), .out_stall(out_stall),
    .sts(sts), .cmd(cmd)
  );

  nnwp_datapath u_dp (
    .clk(clk), .rst(rst), .neighbour_count(neighbour_count),
    .distance(distance), .value(value), .is_self(is_self), .cmd(cmd),
    .sts(sts), .prediction(prediction), .neighbours_used(neighbours_used),
    .exact_match(exact_match), .status(status)
  );
endmodule
